FILE: sv/chol_pkg.sv
// Shared types, constants and an address helper for the Cholesky block.
// Used by chol_ctrl, chol_dp and cholesky_factorization.
package chol_pkg;
	localparam int MAX_ORDER = 8;
	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int AW = $clog2(DEPTH);
	localparam int OW = 4;
	localparam int IW = $clog2(MAX_ORDER);
	localparam int ACCW = 72;

	typedef logic [AW-1:0] addr_t;
	typedef logic [IW-1:0] idx_t;

	// datapath operation codes
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOADA,
		OP_MAC,
		OP_DIV,
		OP_SQRT,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t   op;
		addr_t ra;
		addr_t rb;
		addr_t wa;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic nonpos;
	} sts_t;

	function automatic addr_t rc_addr(idx_t r, idx_t c, logic [OW-1:0] n);
		logic [2*OW-1:0] p;
		p = OW'(r) * n + (2*OW)'(c);
		return p[AW-1:0];
	endfunction
endpackage

FILE: sv/chol_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module chol_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/chol_dp.sv
// Cholesky datapath: matrix and factor RAMs, multiply-accumulate,
// iterative divider and square root. Depends on chol_pkg and chol_ram.
module chol_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ld_we,
	input  chol_pkg::addr_t       ld_addr,
	input  logic signed [31:0]    ld_data,
	input  chol_pkg::cmd_t        cmd,
	output chol_pkg::sts_t        sts,
	output logic signed [31:0]    rd_data
);
	logic signed [31:0] a_rd, fa_rd, fb_rd;
	logic               f_we;
	chol_pkg::addr_t    f_wa;
	logic signed [31:0] f_wd;
	chol_pkg::op_t      op_s1;
	logic signed [chol_pkg::ACCW-1:0] acc_q;
	logic signed [63:0] prod_s2;
	logic               mac_s2;
	logic signed [63:0] prod;
	logic signed [chol_pkg::ACCW-1:0] prod_r;

	chol_ram #(.WIDTH(32), .DEPTH(chol_pkg::DEPTH)) u_a (
		.clk, .we(ld_we), .waddr(ld_addr), .wdata(ld_data),
		.raddr(cmd.ra), .rdata(a_rd));
	chol_ram #(.WIDTH(32), .DEPTH(chol_pkg::DEPTH)) u_fa (
		.clk, .we(f_we), .waddr(f_wa), .wdata(f_wd),
		.raddr(cmd.ra), .rdata(fa_rd));
	chol_ram #(.WIDTH(32), .DEPTH(chol_pkg::DEPTH)) u_fb (
		.clk, .we(f_we), .waddr(f_wa), .wdata(f_wd),
		.raddr(cmd.rb), .rdata(fb_rd));

	assign rd_data = fa_rd;
	assign prod = fa_rd * fb_rd;
	// round to Q16.16: floor((p + 2^15) / 2^16)
	assign prod_r = chol_pkg::ACCW'(($signed(prod) + 64'sd32768) >>> 16);

	// divider / root state
	logic [1:0]  mode_q;
	logic        busy_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic [63:0] num_q, rem_q;
	logic [31:0] den_q;
	logic [63:0] quo_q;
	chol_pkg::addr_t wa_q, wa_s1;
	localparam logic [1:0] M_DIV = 2'd1, M_SQRT = 2'd2;
	logic [64:0] trial;
	logic [64:0] rtrial;
	logic [63:0] qround;
	logic signed [31:0] dres;
	logic [47:0] mag;
	logic signed [chol_pkg::ACCW-1:0] absacc;

	assign absacc = acc_q[chol_pkg::ACCW-1] ? -acc_q : acc_q;
	assign mag = (absacc > chol_pkg::ACCW'(48'h7FFF_FFFF_FFFF)) ? 48'h7FFF_FFFF_FFFF
		: absacc[47:0];

	assign trial = {rem_q, num_q[63]} - {33'd0, den_q};
	// root: rem/num hold remainder and radicand, quo the root
	assign rtrial = {rem_q[62:0], num_q[63:62]} - {quo_q[62:0], 2'b01};

	always_comb begin
		qround = quo_q;
		if (neg_q)
			dres = (qround >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(qround[31:0]);
		else
			dres = (qround > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qround[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mode_q <= 2'd0;
			cnt_q  <= '0;
			mac_s2 <= 1'b0;
			f_we   <= 1'b0;
			op_s1  <= chol_pkg::OP_NONE;
		end else begin
			f_we   <= 1'b0;
			op_s1  <= cmd.op;
			mac_s2 <= op_s1 == chol_pkg::OP_MAC;
			if (op_s1 == chol_pkg::OP_LOADA)
				acc_q <= chol_pkg::ACCW'(a_rd);
			if (mac_s2)
				acc_q <= acc_q - chol_pkg::ACCW'(prod_s2);
			if (op_s1 == chol_pkg::OP_DIV) begin
				busy_q <= 1'b1;
				mode_q <= M_DIV;
				neg_q  <= acc_q[chol_pkg::ACCW-1];
				// (mag*2^16 + d/2) divided by d, 64 bit long division
				num_q  <= {mag, 16'd0} + 64'(fa_rd[31:1]);
				den_q  <= fa_rd;
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= 7'd64;
				wa_q   <= wa_s1;
			end else if (op_s1 == chol_pkg::OP_SQRT) begin
				busy_q <= 1'b1;
				mode_q <= M_SQRT;
				num_q  <= {(acc_q > chol_pkg::ACCW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
					: acc_q[31:0], 16'd0, 16'd0};
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= 7'd24;
				wa_q   <= wa_s1;
			end else if (busy_q && cnt_q != 0) begin
				cnt_q <= cnt_q - 7'd1;
				if (mode_q == M_DIV) begin
					num_q <= {num_q[62:0], 1'b0};
					if (!trial[64]) begin
						rem_q <= trial[63:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], num_q[63]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
				end else begin
					num_q <= {num_q[61:0], 2'b00};
					if (!rtrial[64]) begin
						rem_q <= rtrial[63:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[61:0], num_q[63:62]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
				end
			end else if (busy_q) begin
				busy_q <= 1'b0;
				f_we   <= 1'b1;
				f_wa   <= wa_q;
				if (mode_q == M_DIV)
					f_wd <= dres;
				else
					// round to nearest: remainder above root means bump
					f_wd <= (rem_q > quo_q) ? 32'(quo_q + 64'd1) : quo_q[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= 64'(prod_r);
		if (cmd.op != chol_pkg::OP_NONE)
			wa_s1 <= cmd.wa;
	end

	assign sts.busy   = busy_q || op_s1 != chol_pkg::OP_NONE || mac_s2 || f_we
		|| cmd.op != chol_pkg::OP_NONE;
	assign sts.nonpos = acc_q[chol_pkg::ACCW-1] || acc_q == '0;
endmodule

FILE: sv/chol_ctrl.sv
// Cholesky sequencer: load counting, factor schedule, output streaming.
// Depends on chol_pkg; drives chol_dp through cmd_t and reads sts_t.
module chol_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          order_q,
	input  logic                in_acc,
	output logic                in_stall,
	output logic                ld_we,
	output chol_pkg::addr_t     ld_addr,
	output chol_pkg::cmd_t      cmd,
	input  chol_pkg::sts_t      sts,
	input  logic signed [31:0]  rd_data,
	output logic                valid,
	input  logic                stall,
	output logic signed [31:0]  value,
	output logic                failed,
	output logic                last
);
	localparam logic [2:0] S_LOAD = 3'd0, S_ROW = 3'd1, S_MAC = 3'd2, S_OP = 3'd3,
		S_WAIT = 3'd4, S_CHK = 3'd5, S_OUT = 3'd6, S_FAIL = 3'd7;
	logic [2:0] state_q;
	logic [6:0] cnt_q;
	logic [3:0] n;
	logic [6:0] total;
	chol_pkg::idx_t k_q, j_q, i_q, oc_q, or_q;
	logic [1:0] rd_pend_q;
	logic wt_q;
	logic settle_q;

	assign n = (order_q == 0) ? 4'd1 : (order_q > 4'(chol_pkg::MAX_ORDER))
		? 4'(chol_pkg::MAX_ORDER) : order_q;
	assign total = 7'(n) * 7'(n);
	assign in_stall = state_q != S_LOAD;
	assign ld_we = in_acc && cnt_q < 7'(chol_pkg::DEPTH);
	assign ld_addr = cnt_q[chol_pkg::AW-1:0];

	always_comb begin
		cmd = '0;
		cmd.op = chol_pkg::OP_NONE;
		unique case (state_q)
			S_ROW: begin
				cmd.op = chol_pkg::OP_LOADA;
				cmd.ra = chol_pkg::rc_addr(k_q, j_q, n);
			end
			S_MAC: begin
				cmd.op = chol_pkg::OP_MAC;
				cmd.ra = chol_pkg::rc_addr(j_q, i_q, n);
				cmd.rb = chol_pkg::rc_addr(k_q, i_q, n);
			end
			S_OP: if (!settle_q) begin
				cmd.op = (j_q == k_q) ? chol_pkg::OP_SQRT : chol_pkg::OP_DIV;
				cmd.ra = chol_pkg::rc_addr(j_q, j_q, n);
				cmd.wa = chol_pkg::rc_addr(k_q, j_q, n);
			end
			S_OUT: begin
				cmd.op = chol_pkg::OP_READ;
				cmd.ra = (oc_q <= or_q) ? chol_pkg::rc_addr(or_q, oc_q, n)
					: chol_pkg::rc_addr(oc_q, or_q, n);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			valid     <= 1'b0;
			value     <= '0;
			failed    <= 1'b0;
			last      <= 1'b0;
			rd_pend_q <= '0;
			wt_q      <= 1'b0;
			settle_q  <= 1'b0;
			k_q <= '0; j_q <= '0; i_q <= '0; or_q <= '0; oc_q <= '0;
		end else begin
			if (valid && !stall)
				valid <= 1'b0;
			unique case (state_q)
				S_LOAD: if (in_acc) begin
					if (cnt_q + 7'd1 >= total) begin
						cnt_q <= '0;
						k_q <= '0; j_q <= '0;
						state_q <= S_ROW;
					end else
						cnt_q <= cnt_q + 7'd1;
				end
				S_ROW: begin
					i_q <= '0;
					state_q <= (j_q == 0) ? S_OP : S_MAC;
				end
				S_MAC: begin
					if (i_q + 1'b1 == j_q || (i_q == chol_pkg::IW'(chol_pkg::MAX_ORDER - 1))) begin
						state_q <= S_OP;
						settle_q <= 1'b1;
					end
					i_q <= i_q + 1'b1;
				end
				S_OP: begin
					// wait out settle_q after products so the last one reaches the accumulator
					if (settle_q)
						settle_q <= 1'b0;
					else
						state_q <= S_WAIT;
					wt_q <= 1'b0;
				end
				S_WAIT: begin
					wt_q <= 1'b1;
					if (wt_q && !sts.busy) begin
						if (j_q == k_q) begin
							if (k_q == chol_pkg::IW'(n - 4'd1)) begin
								or_q <= '0; oc_q <= '0;
								state_q <= S_OUT;
							end else begin
								k_q <= k_q + 1'b1;
								j_q <= '0;
								state_q <= S_ROW;
							end
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= S_ROW;
						end
					end
				end
				S_CHK: state_q <= S_LOAD;
				S_OUT: begin
					// RAM data lags the index by the registered read; rd_pend_q waits it out
					if (rd_pend_q == 2'd2)
						rd_pend_q <= 2'd1;
					else if (rd_pend_q == 2'd1) begin
						rd_pend_q <= 2'd0;
						valid <= 1'b1;
						value <= rd_data;
						failed <= 1'b0;
						last <= (or_q == chol_pkg::IW'(n - 4'd1))
							&& (oc_q == chol_pkg::IW'(n - 4'd1));
					end else if (!valid || !stall) begin
						if (valid && last) begin
							state_q <= S_LOAD;
						end else if (valid || (or_q == 0 && oc_q == 0 && !last)) begin
							if (valid) begin
								if (oc_q == chol_pkg::IW'(n - 4'd1)) begin
									oc_q <= '0; or_q <= or_q + 1'b1;
								end else
									oc_q <= oc_q + 1'b1;
							end
							rd_pend_q <= 2'd2;
						end
					end
				end
				S_FAIL: if (!valid) begin
					valid <= 1'b1;
					value <= '0;
					failed <= 1'b1;
					last <= 1'b1;
					// wait in the output state until the transaction is taken
					state_q <= S_OUT;
				end
				default: state_q <= S_LOAD;
			endcase
			// pivot check once the sqrt operand is in the accumulator
			if (state_q == S_OP && !settle_q && j_q == k_q)
				state_q <= S_CHK;
			if (state_q == S_CHK && sts.nonpos)
				state_q <= S_FAIL;
			if (state_q == S_CHK && !sts.nonpos)
				state_q <= S_WAIT;
			if (state_q == S_LOAD)
				last <= 1'b0;
		end
	end
endmodule

FILE: sv/cholesky_factorization.sv
// Cholesky factorization block: top level joining sequencer and datapath.
// Depends on chol_pkg, chol_ctrl, chol_dp, chol_ram.
//
// Usage: write the matrix order (1..8) on the cfg channel while idle; 0
// acts as 1 and values above 8 act as 8. Stream n*n Q16.16 elements in
// row-major order on element/in_valid; only the lower triangle is used.
// After the last element the input stalls while the factor is formed:
// each off-diagonal entry passes the 64-step divider, each pivot the
// 24-step root, after one multiply-accumulate per product.
// The result is n*n transactions on value/valid, row-major, L below and
// L transposed above the diagonal, with last on the final one; a
// non-positive pivot gives a single transaction with failed and last set.
// Outputs are read from the factor RAM one at a time; downstream stall just
// holds the output register. Reset clears the load count and sets order 8.
module cholesky_factorization (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         order,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] element,
	output logic               valid,
	input  logic               stall,
	output logic signed [31:0] value,
	output logic               failed,
	output logic               last
);
	logic [3:0] order_q;
	logic in_acc, ld_we;
	chol_pkg::addr_t ld_addr;
	chol_pkg::cmd_t cmd;
	chol_pkg::sts_t sts;
	logic signed [31:0] rd_data;

	assign cfg_ready = 1'b1;
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			order_q <= 4'd8;
		else if (cfg_valid && cfg_ready)
			order_q <= order;
	end

	chol_ctrl u_ctrl (
		.clk, .arst_n, .order_q, .in_acc, .in_stall, .ld_we, .ld_addr,
		.cmd, .sts, .rd_data, .valid, .stall, .value, .failed, .last);

	chol_dp u_dp (
		.clk, .arst_n, .ld_we, .ld_addr, .ld_data(element), .cmd, .sts, .rd_data);

	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && failed |-> last) else $error("failure result without last");
	a_no_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> in_stall) else $error("input open while results pending");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && failed |-> value == 0) else $error("failure value not zero");
endmodule
